/* hw/rtl/spmm_pkg.sv */
// Shared types and constants for the sparse triplet matrix multiplier.
`default_nettype none

package spmm_pkg;

    // Field widths fixed by the word format
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = 40;
    localparam int CFG_W  = 9;

    // Product table geometry
    localparam int TBL_DEPTH = 64;
    localparam int TBL_AW    = 6;
    localparam int PC_W      = 7;

    // Input word kinds
    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIM_BAD  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic CFG_A_COLUMNS = 1'b0;
    localparam logic CFG_B_ROWS    = 1'b1;

    // One stored nonzero term
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } term_t;

    // One product table entry
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] sum;
    } entry_t;

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_BCHK = 10'b0000000100,
        S_TRD  = 10'b0000001000,
        S_TCHK = 10'b0000010000,
        S_NEW  = 10'b0000100000,
        S_FIN  = 10'b0001000000,
        S_ERD  = 10'b0010000000,
        S_ELD  = 10'b0100000000,
        S_STAT = 10'b1000000000
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/spmm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module spmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/sparse_triplet_matrix_multiply.sv */
// Top level: sparse matrix product over (row, col, value) triplets.
`default_nettype none

// Usage:
//   Input channel (in_valid/in_ready) takes one word per handshake. kind selects
//   load of an A term, load of a B term, or compute. Kind 3 is dropped.
//   Load words are taken one per cycle while idle and produce no result; a
//   load into a full term store is dropped and flags the run as overflowed.
//   A compute word checks a_columns against b_rows, then walks every A/B term
//   pair (S_RD reads both registered term RAMs, S_BCHK compares), and for each
//   pair whose inner indexes match scans the product table RAM for a matching
//   key (S_TRD then S_TCHK per entry visited, S_NEW to create a new entry).
//   Products then leave from the table RAM through the output register.
//   in_ready stays low from the compute word until its final result is in the
//   output register; loads may follow while that word still waits on out_ready.
//   Output channel (out_valid/out_ready): one word per product entry in
//   first-seen order, last set on the final one; error and empty cases give
//   a single status word with last set. A stalled receiver holds the sequencer.
//   Configuration (cfg_write/cfg_index/cfg_data) must be written while idle (not
//   enforced). Reset clears counts, flags and sequencer; RAMs need no clearing.
module sparse_triplet_matrix_multiply
    import spmm_pkg::*;
#(
    parameter int MAX_A_TERMS = 8,
    parameter int MAX_B_TERMS = 8,
    parameter int MAX_DIM     = 256,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration
    input  wire logic                    cfg_write,
    input  wire logic                    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    // input words
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              kind,
    input  wire logic [IDX_W-1:0]        term_row,
    input  wire logic [IDX_W-1:0]        term_col,
    input  wire logic signed [VAL_W-1:0] term_value,
    // result words
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [IDX_W-1:0]             out_row,
    output logic [IDX_W-1:0]             out_col,
    output logic signed [SUM_W-1:0]      out_val,
    output logic                         last,
    output logic [1:0]                   status
);

    localparam int A_CW = $clog2(MAX_A_TERMS + 1);
    localparam int B_CW = $clog2(MAX_B_TERMS + 1);
    localparam int A_AW = (MAX_A_TERMS > 1) ? $clog2(MAX_A_TERMS) : 1;
    localparam int B_AW = (MAX_B_TERMS > 1) ? $clog2(MAX_B_TERMS) : 1;
    localparam int VB   = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int VSH  = VAL_W - VB;

    // Registers
    logic [CFG_W-1:0]        a_columns_reg, a_columns_next;
    logic [CFG_W-1:0]        b_rows_reg, b_rows_next;
    state_t                  state_reg, state_next;
    logic [A_CW-1:0]         a_count_reg, a_count_next;
    logic [B_CW-1:0]         b_count_reg, b_count_next;
    logic                    ovf_reg, ovf_next;
    logic [PC_W-1:0]         pc_reg, pc_next;
    logic [A_CW-1:0]         i_reg, i_next;
    logic [B_CW-1:0]         j_reg, j_next;
    logic [PC_W-1:0]         x_reg, x_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [IDX_W-1:0]        key_row_reg, key_row_next;
    logic [IDX_W-1:0]        key_col_reg, key_col_next;
    logic [1:0]              code_reg, code_next;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        out_row_reg, out_row_next;
    logic [IDX_W-1:0]        out_col_reg, out_col_next;
    logic [SUM_W-1:0]        out_val_reg, out_val_next;
    logic                    last_reg, last_next;
    logic [1:0]              status_reg, status_next;

    // RAM ports
    logic                    a_we, b_we, t_we;
    logic [31:0]             a_rdata, b_rdata;
    logic [$bits(entry_t)-1:0] t_rdata;
    entry_t                  t_wdata;
    logic [TBL_AW-1:0]       t_waddr;
    term_t                   a_rd, b_rd, ld_term;
    entry_t                  t_rd;

    // Combinational helpers
    logic signed [VAL_W-1:0] val_shl, val_ext;
    logic                    in_acc, out_free, out_load;
    logic                    dim_bad;
    logic [B_CW-1:0]         j_inc;
    logic [A_CW-1:0]         i_inc;
    logic [PC_W-1:0]         x_inc;
    logic signed [SUM_W-1:0] prod_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Loaded value taken as VALUE_BITS wide, signed
    assign val_shl = term_value <<< VSH;
    assign val_ext = val_shl >>> VSH;
    assign ld_term = '{row: term_row, col: term_col, value: val_ext};

    assign a_rd     = term_t'(a_rdata);
    assign b_rd     = term_t'(b_rdata);
    assign t_rd     = entry_t'(t_rdata);
    assign prod_ext = SUM_W'(prod_reg);

    assign dim_bad = (a_columns_reg != b_rows_reg) || (a_columns_reg == '0)
                     || (32'(a_columns_reg) > 32'(MAX_DIM));

    assign j_inc = j_reg + 1'b1;
    assign i_inc = i_reg + 1'b1;
    assign x_inc = x_reg + 1'b1;

    assign a_we = in_acc && (kind == KIND_LOAD_A) && (a_count_reg < A_CW'(MAX_A_TERMS));
    assign b_we = in_acc && (kind == KIND_LOAD_B) && (b_count_reg < B_CW'(MAX_B_TERMS));

    // Term stores and product table
    spmm_ram #(.WIDTH(32), .DEPTH(MAX_A_TERMS)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_count_reg[A_AW-1:0]),
        .wdata (ld_term),
        .raddr (i_reg[A_AW-1:0]),
        .rdata (a_rdata)
    );

    spmm_ram #(.WIDTH(32), .DEPTH(MAX_B_TERMS)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_count_reg[B_AW-1:0]),
        .wdata (ld_term),
        .raddr (j_reg[B_AW-1:0]),
        .rdata (b_rdata)
    );

    spmm_ram #(.WIDTH($bits(entry_t)), .DEPTH(TBL_DEPTH)) u_t_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (x_reg[TBL_AW-1:0]),
        .rdata (t_rdata)
    );

    // Configuration registers
    always_comb
    begin
        a_columns_next = a_columns_reg;
        b_rows_next    = b_rows_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_A_COLUMNS: a_columns_next = cfg_data;
                CFG_B_ROWS:    b_rows_next    = cfg_data;
                default:       ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        a_count_next = a_count_reg;
        b_count_next = b_count_reg;
        ovf_next     = ovf_reg;
        pc_next      = pc_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        x_next       = x_reg;
        prod_next    = prod_reg;
        key_row_next = key_row_reg;
        key_col_next = key_col_reg;
        code_next    = code_reg;
        out_load     = 1'b0;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        out_val_next = out_val_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        t_we         = 1'b0;
        t_waddr      = x_reg[TBL_AW-1:0];
        t_wdata      = '{row: key_row_reg, col: key_col_reg, sum: t_rd.sum + prod_ext};

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (kind)
                        KIND_LOAD_A:
                        begin
                            if (a_we)
                                a_count_next = a_count_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        KIND_LOAD_B:
                        begin
                            if (b_we)
                                b_count_next = b_count_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        KIND_COMPUTE:
                        begin
                            pc_next = '0;
                            i_next  = '0;
                            j_next  = '0;
                            if (dim_bad)
                            begin
                                code_next  = ST_DIM_BAD;
                                state_next = S_STAT;
                            end
                            else if (ovf_reg)
                            begin
                                code_next  = ST_OVERFLOW;
                                state_next = S_STAT;
                            end
                            else if (a_count_reg == '0 || b_count_reg == '0)
                                state_next = S_FIN;
                            else
                                state_next = S_RD;
                        end
                        default: ;
                    endcase
                end
            end

            // term reads for pair (i, j) in flight
            S_RD:
                state_next = S_BCHK;

            S_BCHK:
            begin
                prod_next    = $signed(a_rd.value) * $signed(b_rd.value);
                key_row_next = a_rd.row;
                key_col_next = b_rd.col;
                x_next       = '0;
                if (a_rd.col == b_rd.row)
                    state_next = (pc_reg == '0) ? S_NEW : S_TRD;
                else if (j_inc != b_count_reg)
                begin
                    j_next     = j_inc;
                    state_next = S_RD;
                end
                else if (i_inc != a_count_reg)
                begin
                    i_next     = i_inc;
                    j_next     = '0;
                    state_next = S_RD;
                end
                else
                    state_next = S_FIN;
            end

            // table read for entry x in flight
            S_TRD:
                state_next = S_TCHK;

            S_TCHK:
            begin
                if (t_rd.row == key_row_reg && t_rd.col == key_col_reg)
                begin
                    t_we = 1'b1;
                    if (j_inc != b_count_reg)
                    begin
                        j_next     = j_inc;
                        state_next = S_RD;
                    end
                    else if (i_inc != a_count_reg)
                    begin
                        i_next     = i_inc;
                        j_next     = '0;
                        state_next = S_RD;
                    end
                    else
                        state_next = S_FIN;
                end
                else
                begin
                    x_next     = x_inc;
                    state_next = (x_inc == pc_reg) ? S_NEW : S_TRD;
                end
            end

            // append a new entry in first-seen order
            S_NEW:
            begin
                if (pc_reg == PC_W'(TBL_DEPTH))
                begin
                    code_next  = ST_OVERFLOW;
                    state_next = S_STAT;
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = pc_reg[TBL_AW-1:0];
                    t_wdata = '{row: key_row_reg, col: key_col_reg, sum: prod_ext};
                    pc_next = pc_reg + 1'b1;
                    if (j_inc != b_count_reg)
                    begin
                        j_next     = j_inc;
                        state_next = S_RD;
                    end
                    else if (i_inc != a_count_reg)
                    begin
                        i_next     = i_inc;
                        j_next     = '0;
                        state_next = S_RD;
                    end
                    else
                        state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                x_next = '0;
                if (pc_reg == '0)
                begin
                    code_next  = ST_EMPTY;
                    state_next = S_STAT;
                end
                else
                    state_next = S_ERD;
            end

            S_ERD:
                state_next = S_ELD;

            // move one product word into the output register
            S_ELD:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_row_next = t_rd.row;
                    out_col_next = t_rd.col;
                    out_val_next = t_rd.sum;
                    status_next  = ST_OK;
                    last_next    = (x_inc == pc_reg);
                    if (x_inc == pc_reg)
                    begin
                        a_count_next = '0;
                        b_count_next = '0;
                        ovf_next     = 1'b0;
                        pc_next      = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        x_next     = x_inc;
                        state_next = S_ERD;
                    end
                end
            end

            // single status word ends the run
            S_STAT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_row_next = '0;
                    out_col_next = '0;
                    out_val_next = '0;
                    status_next  = code_reg;
                    last_next    = 1'b1;
                    a_count_next = '0;
                    b_count_next = '0;
                    ovf_next     = 1'b0;
                    pc_next      = '0;
                    state_next   = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register handshake
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_columns_reg <= CFG_W'(1);
            b_rows_reg    <= CFG_W'(1);
            a_count_reg   <= '0;
            b_count_reg   <= '0;
            ovf_reg       <= 1'b0;
            pc_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            x_reg         <= '0;
            code_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_columns_reg <= a_columns_next;
            b_rows_reg    <= b_rows_next;
            a_count_reg   <= a_count_next;
            b_count_reg   <= b_count_next;
            ovf_reg       <= ovf_next;
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            x_reg         <= x_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        key_row_reg <= key_row_next;
        key_col_reg <= key_col_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        out_val_reg <= out_val_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_val   = out_val_reg;
    assign last      = last_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // final word of a run leaves the stores empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> (a_count_reg == '0 && b_count_reg == '0 && !ovf_reg
                                     && pc_reg == '0))
        else $error("run state not cleared after final word");

    // table scan never passes the filled entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TCHK || state_reg == S_ELD) |-> (x_reg < pc_reg))
        else $error("table index beyond fill count");

    // fill count bounded by table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_W'(TBL_DEPTH))
        else $error("product count exceeds table depth");

    // a status-only word is always the last of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> last_reg)
        else $error("error status without last");
`endif

endmodule

`default_nettype wire
